// ===== src/touch_wheel_scroll_decoder_assert.svh =====
// Assertion macros used by the top level of the touch wheel scroll decoder.
`ifndef TOUCH_WHEEL_SCROLL_DECODER_ASSERT_SVH
`define TOUCH_WHEEL_SCROLL_DECODER_ASSERT_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define TWSD_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition that must hold in the cycle after its trigger.
`define TWSD_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== src/twsd_pkg.sv =====
// Package with word types, register indexes and constants of the scroll decoder.
`timescale 1ns / 1ps

package twsd_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WHEEL_POSITIONS = 2'd0,
      CSR_STEP_THRESHOLD  = 2'd1,
      CSR_RELEASE_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [31:0] SIG_MASK  = 32'h8000_00FF;
   localparam logic [31:0] SIG_VALUE = 32'h8000_001A;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam int unsigned TOUCH_BIT = 30;

   localparam logic [7:0]  WHEEL_POSITIONS_RESET = 8'd96;
   localparam logic [6:0]  STEP_THRESHOLD_RESET  = 7'd5;
   localparam logic [31:0] RELEASE_TIMEOUT_RESET = 32'd500000;

   typedef struct packed {
      logic [31:0] now_ticks;
      logic        packet_present;
      logic [31:0] status_word;
   } req_type;

   typedef struct packed {
      logic [4:0] buttons;
      logic       scroll_right;
      logic       scroll_left;
      logic       packet_accepted;
      logic       reinit_request;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  wheel_positions;
      logic [6:0]  step_threshold;
      logic [31:0] release_timeout;
   } cfg_type;

endpackage

// ===== src/twsd_csr.sv =====
// Configuration registers of the scroll decoder.
`timescale 1ns / 1ps

module twsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [twsd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [twsd_pkg::CsrDataWidth-1:0]   csr_wdata,
   output twsd_pkg::cfg_type                   cfg
);

   twsd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_positions <= twsd_pkg::WHEEL_POSITIONS_RESET;
         cfg_ff.step_threshold  <= twsd_pkg::STEP_THRESHOLD_RESET;
         cfg_ff.release_timeout <= twsd_pkg::RELEASE_TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            twsd_pkg::CSR_WHEEL_POSITIONS: cfg_ff.wheel_positions <= csr_wdata[7:0];
            twsd_pkg::CSR_STEP_THRESHOLD:  cfg_ff.step_threshold  <= csr_wdata[6:0];
            twsd_pkg::CSR_RELEASE_TIMEOUT: cfg_ff.release_timeout <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/twsd_wheel.sv =====
// Wheel tracking state, release timeout and step decision for one status word.
`timescale 1ns / 1ps

module twsd_wheel (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  twsd_pkg::req_type req,
   input  twsd_pkg::cfg_type cfg,
   output twsd_pkg::rsp_type rsp
);

   logic        touched_ff, touched_in;
   logic [6:0]  position_ff, position_in;
   logic        armed_ff, armed_in;
   logic [31:0] last_move_ff, last_move_in;

   logic [31:0]        elapsed;
   logic               timed_out;
   logic               touched_eff;
   logic               armed_eff;
   logic               sig_match;
   logic               touch;
   logic [6:0]         new_pos;
   logic signed [10:0] ts, ws, ps, thr;
   logic signed [10:0] fwd, bwd, adj, diff;
   logic               step_right, step_left, tracking;

   always_comb begin
      elapsed     = req.now_ticks - last_move_ff;
      timed_out   = armed_ff && (elapsed > cfg.release_timeout);
      touched_eff = touched_ff && !timed_out;
      armed_eff   = armed_ff && !timed_out;
      sig_match   = req.packet_present
                    && ((req.status_word & twsd_pkg::SIG_MASK) == twsd_pkg::SIG_VALUE);
      touch       = req.status_word[twsd_pkg::TOUCH_BIT];
      new_pos     = req.status_word[22:16];

      ts  = $signed({4'b0, new_pos});
      ws  = $signed({4'b0, position_ff});
      ps  = $signed({3'b0, cfg.wheel_positions});
      thr = $signed({4'b0, cfg.step_threshold});
      fwd = ts - ws;
      bwd = ws - ts;
      adj = ts;
      if (ts > ws) begin
         if (fwd > (ps - fwd)) adj = ts - ps;
      end else begin
         if (bwd > (ps - bwd)) adj = ts + ps;
      end
      diff = adj - ws;

      tracking   = sig_match && touch && touched_eff;
      step_right = tracking && (diff >= thr);
      step_left  = tracking && !(diff >= thr) && (diff <= -thr);

      touched_in   = touched_eff;
      position_in  = position_ff;
      armed_in     = armed_eff;
      last_move_in = last_move_ff;
      if (sig_match) begin
         if (touch) begin
            if (!touched_eff || step_right || step_left) begin
               touched_in   = 1'b1;
               position_in  = new_pos;
               armed_in     = 1'b1;
               last_move_in = req.now_ticks;
            end else if (position_ff != new_pos) begin
               armed_in     = 1'b1;
               last_move_in = req.now_ticks;
            end
         end else begin
            touched_in = 1'b0;
         end
      end

      rsp.buttons         = sig_match ? req.status_word[12:8] : 5'd0;
      rsp.scroll_right    = step_right;
      rsp.scroll_left     = step_left;
      rsp.packet_accepted = sig_match;
      rsp.reinit_request  = req.packet_present && !sig_match
                            && (req.status_word == twsd_pkg::ALL_ONES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff   <= 1'b0;
         position_ff  <= 7'd0;
         armed_ff     <= 1'b0;
         last_move_ff <= 32'd0;
      end else if (step_en) begin
         touched_ff   <= touched_in;
         position_ff  <= position_in;
         armed_ff     <= armed_in;
         last_move_ff <= last_move_in;
      end
   end

endmodule

// ===== src/touch_wheel_scroll_decoder.sv =====
// A word accepted at req waits in the input register stage; its result is then
// registered in the output stage and rsp_valid rises, unless a full output stage
// holds it. Throughput: one word per cycle while rsp_ready is high; the wheel
// state update for a word is finished as it leaves the input register stage.
// Reset (synchronous, active high) clears both stage valids, the wheel state
// and loads the register defaults; no clearing pass.
// Top level of the touch wheel scroll decoder.
`timescale 1ns / 1ps

`include "touch_wheel_scroll_decoder_assert.svh"

module touch_wheel_scroll_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  twsd_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output twsd_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [twsd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [twsd_pkg::CsrDataWidth-1:0]  csr_wdata
);

   logic               in_valid_ff;
   twsd_pkg::req_type  in_data_ff;
   logic               out_valid_ff;
   twsd_pkg::rsp_type  out_data_ff;
   logic               advance;
   twsd_pkg::cfg_type  cfg;
   twsd_pkg::rsp_type  step_rsp;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   twsd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   twsd_wheel u_wheel (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= step_rsp;
   end

   `TWSD_ASSERT_NOW(a_one_direction, clock, reset, rsp_valid,
      !(rsp_data.scroll_right && rsp_data.scroll_left), "both scroll directions set")
   `TWSD_ASSERT_NOW(a_step_needs_packet, clock, reset,
      rsp_valid && (rsp_data.scroll_right || rsp_data.scroll_left),
      rsp_data.packet_accepted, "scroll step without accepted word")
   `TWSD_ASSERT_NOW(a_reinit_alone, clock, reset, rsp_valid && rsp_data.reinit_request,
      !rsp_data.packet_accepted && (rsp_data.buttons == 5'd0), "reinit with packet fields")
   `TWSD_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && req_ready,
      in_valid_ff, "accepted word not held in input stage")

endmodule
